// ===== rtl/sppt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine package
// Shared types, opcodes, controller states and command structures.
// ----------------------------------------------------------------------------
package sppt_pkg;

  localparam int TERM_SLOTS_DEF = 16;
  localparam int EXPO_BITS_DEF  = 8;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_INS_A    = 3'd1,
    OP_INS_B    = 3'd2,
    OP_MERGE    = 3'd3,
    OP_EVAL     = 3'd4,
    OP_READ     = 3'd5,
    OP_UNUSED6  = 3'd6,
    OP_UNUSED7  = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] coef_in;
    logic [7:0]  expo_in;
    logic [31:0] x_value;
    logic [3:0]  term_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] eval_value;
    logic [31:0] read_coef;
    logic [7:0]  read_expo;
    logic        read_present;
    logic        overflow;
    logic [4:0]  term_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_MERGE,
    ST_EVAL_TERM,
    ST_EVAL_POW,
    ST_EVAL_ACC,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic clr_step;    // clear one slot of every table
    logic ins_scan;    // compare one slot during an insert
    logic ins_shift;   // move one slot down during an insert
    logic merge_step;  // emit one merged term
    logic eval_term;   // start the power of one D term
    logic pow_step;    // one square-and-multiply step
    logic acc_step;    // add coef*power to the accumulator
    logic finish;      // build the result item
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic ins_found;   // scan reached its end (match, place or table end)
    logic ins_shift_done;
    logic merge_done;
    logic eval_done;
    logic pow_done;
  } sts_t;

endpackage

// ===== rtl/sppt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine controller
// Sequences one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module sppt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_op,
  output logic            out_valid,
  input  logic            out_stall,
  output sppt_pkg::cmd_t  cmd,
  input  sppt_pkg::sts_t  sts
);
  import sppt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  // A new item is taken only when idle and the result register is free.
  assign in_stall  = !(state_r == ST_IDLE && !out_valid_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_CLEAR:         state_nxt = ST_CLEAR;
            OP_INS_A, OP_INS_B: state_nxt = ST_INS_SCAN;
            OP_MERGE:         state_nxt = ST_MERGE;
            OP_EVAL:          state_nxt = ST_EVAL_TERM;
            default:          state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_DONE;
      end
      ST_INS_SCAN: begin
        cmd.ins_scan = 1'b1;
        if (sts.ins_found) state_nxt = ST_INS_SHIFT;
      end
      ST_INS_SHIFT: begin
        cmd.ins_shift = 1'b1;
        if (sts.ins_shift_done) state_nxt = ST_DONE;
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
        if (sts.merge_done) state_nxt = ST_DONE;
      end
      ST_EVAL_TERM: begin
        if (sts.eval_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.eval_term = 1'b1;
          state_nxt = ST_EVAL_POW;
        end
      end
      ST_EVAL_POW: begin
        cmd.pow_step = 1'b1;
        if (sts.pow_done) state_nxt = ST_EVAL_ACC;
      end
      ST_EVAL_ACC: begin
        cmd.acc_step = 1'b1;
        state_nxt = ST_EVAL_TERM;
      end
      ST_DONE: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/sppt_dp.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine datapath
// Term tables, insert/merge pointers, power unit and result register.
// ----------------------------------------------------------------------------
module sppt_dp #(
  parameter int TERM_SLOTS = sppt_pkg::TERM_SLOTS_DEF,
  parameter int EXPO_BITS  = sppt_pkg::EXPO_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sppt_pkg::in_item_t   in_data,
  input  sppt_pkg::cmd_t       cmd,
  output sppt_pkg::sts_t       sts,
  output sppt_pkg::out_item_t  out_data
);
  import sppt_pkg::*;

  localparam int IW = $clog2(TERM_SLOTS);
  localparam int CW = $clog2(TERM_SLOTS + 1);
  localparam int PW = (EXPO_BITS > 1) ? $clog2(EXPO_BITS + 1) : 1;

  logic [31:0]          a_cf_r [TERM_SLOTS];
  logic [EXPO_BITS-1:0] a_ex_r [TERM_SLOTS];
  logic [31:0]          b_cf_r [TERM_SLOTS];
  logic [EXPO_BITS-1:0] b_ex_r [TERM_SLOTS];
  logic [31:0]          d_cf_r [TERM_SLOTS];
  logic [EXPO_BITS-1:0] d_ex_r [TERM_SLOTS];
  logic [CW-1:0]        a_cnt_r, b_cnt_r, d_cnt_r;

  in_item_t             it_r;
  logic [CW-1:0]        i_r, j_r, k_r;   // generic pointers
  logic                 ov_r;
  logic                 hit_r;           // insert found same exponent
  logic                 drop_r;          // insert has nothing to do
  logic [31:0]          acc_r, pw_r, base_r, tcf_r;
  logic [EXPO_BITS-1:0] ex_r;
  logic [PW-1:0]        bit_r;
  out_item_t            out_r;
  out_item_t            out_nxt;

  logic                 sel_b;
  logic [EXPO_BITS-1:0] in_ex;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        ii, ji, di;
  logic [EXPO_BITS-1:0] ex_i;
  logic                 a_more, b_more, take_a, take_b;
  logic [31:0]          m_c;
  logic [EXPO_BITS-1:0] m_e;

  assign sel_b = (it_r.op == OP_INS_B);
  assign in_ex = it_r.expo_in[EXPO_BITS-1:0];
  assign cnt   = sel_b ? b_cnt_r : a_cnt_r;
  assign ii    = i_r[IW-1:0];
  assign ji    = j_r[IW-1:0];
  assign di    = k_r[IW-1:0];
  assign ex_i  = sel_b ? b_ex_r[ii] : a_ex_r[ii];

  assign a_more = i_r < a_cnt_r;
  assign b_more = j_r < b_cnt_r;
  assign take_a = a_more && (!b_more || a_ex_r[ii] > b_ex_r[ji]);
  assign take_b = b_more && (!a_more || b_ex_r[ji] > a_ex_r[ii]);
  always_comb begin
    if (take_a) begin
      m_c = a_cf_r[ii];
      m_e = a_ex_r[ii];
    end else if (take_b) begin
      m_c = b_cf_r[ji];
      m_e = b_ex_r[ji];
    end else begin
      m_c = a_cf_r[ii] + b_cf_r[ji];
      m_e = a_ex_r[ii];
    end
  end

  always_comb begin
    sts = '0;
    sts.clr_last       = (i_r == CW'(TERM_SLOTS - 1));
    sts.ins_found      = drop_r || (i_r >= cnt) || (ex_i <= in_ex);
    sts.ins_shift_done = drop_r || hit_r || (k_r <= i_r);
    sts.merge_done     = !a_more && !b_more;
    sts.eval_done      = (k_r >= d_cnt_r);
    sts.pow_done       = (bit_r == PW'(EXPO_BITS - 1));
  end

  // Result item for the operation that is finishing.
  always_comb begin
    out_nxt = '0;
    case (it_r.op)
      OP_INS_A: begin
        out_nxt.overflow   = ov_r;
        out_nxt.term_count = 5'(a_cnt_r);
      end
      OP_INS_B: begin
        out_nxt.overflow   = ov_r;
        out_nxt.term_count = 5'(b_cnt_r);
      end
      OP_MERGE: begin
        out_nxt.overflow   = ov_r;
        out_nxt.term_count = 5'(d_cnt_r);
      end
      OP_EVAL: begin
        out_nxt.eval_value = acc_r;
        out_nxt.term_count = 5'(d_cnt_r);
      end
      OP_READ: begin
        out_nxt.term_count = 5'(d_cnt_r);
        if ({1'b0, it_r.term_index} < 5'(d_cnt_r) &&
            32'(it_r.term_index) < 32'(TERM_SLOTS)) begin
          out_nxt.read_coef    = d_cf_r[IW'(it_r.term_index)];
          out_nxt.read_expo    = 8'(d_ex_r[IW'(it_r.term_index)]);
          out_nxt.read_present = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      d_cnt_r <= '0;
      for (int s = 0; s < TERM_SLOTS; s++) begin
        a_cf_r[s] <= '0; a_ex_r[s] <= '0;
        b_cf_r[s] <= '0; b_ex_r[s] <= '0;
        d_cf_r[s] <= '0; d_ex_r[s] <= '0;
      end
    end else begin
      if (cmd.clr_step) begin
        a_cf_r[ii] <= '0; a_ex_r[ii] <= '0;
        b_cf_r[ii] <= '0; b_ex_r[ii] <= '0;
        d_cf_r[ii] <= '0; d_ex_r[ii] <= '0;
        a_cnt_r <= '0; b_cnt_r <= '0; d_cnt_r <= '0;
      end
      if (cmd.ins_shift && !drop_r) begin
        if (hit_r) begin
          if (sel_b) b_cf_r[ii] <= it_r.coef_in;
          else       a_cf_r[ii] <= it_r.coef_in;
        end else if (k_r > i_r) begin
          // Move slot k-1 into slot k, walking up toward the insert point.
          if (sel_b) begin
            b_cf_r[di] <= b_cf_r[IW'(k_r - CW'(1))];
            b_ex_r[di] <= b_ex_r[IW'(k_r - CW'(1))];
          end else begin
            a_cf_r[di] <= a_cf_r[IW'(k_r - CW'(1))];
            a_ex_r[di] <= a_ex_r[IW'(k_r - CW'(1))];
          end
        end else begin
          if (sel_b) begin
            b_cf_r[di] <= it_r.coef_in; b_ex_r[di] <= in_ex;
            b_cnt_r    <= b_cnt_r + CW'(1);
          end else begin
            a_cf_r[di] <= it_r.coef_in; a_ex_r[di] <= in_ex;
            a_cnt_r    <= a_cnt_r + CW'(1);
          end
        end
      end
      if (cmd.load && in_data.op == OP_MERGE) begin
        d_cnt_r <= '0;
      end
      if (cmd.merge_step && !sts.merge_done && m_c != '0 &&
          k_r < CW'(TERM_SLOTS)) begin
        d_cf_r[di] <= m_c;
        d_ex_r[di] <= m_e;
        d_cnt_r    <= k_r + CW'(1);
      end
      if (cmd.merge_step && sts.merge_done) begin
        // Slots past the new count read as zero.
        for (int s = 0; s < TERM_SLOTS; s++) begin
          if (CW'(s) >= k_r) begin
            d_cf_r[s] <= '0;
            d_ex_r[s] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r   <= in_data;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      ov_r   <= 1'b0;
      hit_r  <= 1'b0;
      drop_r <= (in_data.coef_in == '0);
      acc_r  <= '0;
    end
    if (cmd.clr_step) i_r <= i_r + CW'(1);
    if (cmd.ins_scan) begin
      if (sts.ins_found) begin
        if (!drop_r && i_r < cnt && ex_i == in_ex) begin
          hit_r <= 1'b1;
        end else if (!drop_r && cnt >= CW'(TERM_SLOTS)) begin
          drop_r <= 1'b1;
          ov_r   <= 1'b1;
        end
        k_r <= cnt;
      end else begin
        i_r <= i_r + CW'(1);
      end
    end
    if (cmd.ins_shift && !drop_r && !hit_r && k_r > i_r) k_r <= k_r - CW'(1);
    if (cmd.merge_step && !sts.merge_done) begin
      if (take_a) i_r <= i_r + CW'(1);
      else if (take_b) j_r <= j_r + CW'(1);
      else begin
        i_r <= i_r + CW'(1);
        j_r <= j_r + CW'(1);
      end
      if (m_c != '0) begin
        if (k_r < CW'(TERM_SLOTS)) k_r <= k_r + CW'(1);
        else ov_r <= 1'b1;
      end
    end
    if (cmd.eval_term) begin
      tcf_r  <= d_cf_r[di];
      ex_r   <= d_ex_r[di];
      base_r <= it_r.x_value;
      pw_r   <= 32'd1;
      bit_r  <= '0;
    end
    if (cmd.pow_step) begin
      if (ex_r[0]) pw_r <= pw_r * base_r;
      base_r <= base_r * base_r;
      ex_r   <= ex_r >> 1;
      bit_r  <= bit_r + PW'(1);
    end
    if (cmd.acc_step) begin
      acc_r <= acc_r + tcf_r * pw_r;
      k_r   <= k_r + CW'(1);
    end
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/sparse_polynomial_term_engine.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine
// Holds polynomials A, B and D as sorted term tables; clears, inserts, merges,
// evaluates and reads terms one operation at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  sppt_pkg::in_item_t
//   out_     output     out_valid/ out_stall sppt_pkg::out_item_t
//
// One operation is in flight at a time; the next transfer is taken after the
// result register has been emptied. Clear steps through the slots, an insert
// scans and then shifts, a merge walks A and B together, and evaluation
// raises each D term in turn with the shared square-and-multiply unit.
// Reset (rst_n low, synchronous) empties all tables at once. A stalled result
// holds its value; the input stays stalled until it has been transferred.
module sparse_polynomial_term_engine #(
  parameter int TERM_SLOTS = sppt_pkg::TERM_SLOTS_DEF,
  parameter int EXPO_BITS  = sppt_pkg::EXPO_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sppt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sppt_pkg::out_item_t  out_data
);
  import sppt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshakes and steps the datapath.
  sppt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_data.op),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the tables and the result register.
  sppt_dp #(
    .TERM_SLOTS(TERM_SLOTS),
    .EXPO_BITS (EXPO_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

// ===== rtl/sppt_checker.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sppt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sppt_pkg::out_item_t out_data
);
  import sppt_pkg::*;

  // A result never coexists with an open input.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

  // A transfer in is never answered in the next cycle's edge.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Counts never exceed the table size.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.term_count <= 5'(TERM_SLOTS_DEF)))
    else $error("bad count");

endmodule

bind sparse_polynomial_term_engine sppt_checker u_sppt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/sparse_polynomial_term_engine_test.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term engine testbench
// Drives random and directed operations through the valid/stall channels,
// predicts every result with a local model of the three term tables and
// compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sparse_polynomial_term_engine_test;
  import sppt_pkg::*;

  localparam int SLOTS = TERM_SLOTS_DEF;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  sparse_polynomial_term_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predicted contents of the three polynomials.
  typedef struct {
    logic [31:0] coef [SLOTS];
    logic [7:0]  expo [SLOTS];
    int          count;
  } poly_t;

  poly_t poly_a, poly_b, poly_d;
  in_item_t  pending_ops [$];
  out_item_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int ops_sent = 0;
  int ops_offered = 0;
  int cycle_count = 0;
  bit quiet_mode = 1'b0;     // both sides run without idling
  bit receiver_hold = 1'b0;  // long receiver hold-off, timed in its own process
  int overflow_hits = 0;

  function automatic void poly_clear(ref poly_t p);
    for (int i = 0; i < SLOTS; i++) begin
      p.coef[i] = '0;
      p.expo[i] = '0;
    end
    p.count = 0;
  endfunction

  // Inserts one term in descending exponent order; returns 1 when lost to a full table.
  function automatic bit poly_insert(ref poly_t p, input logic [31:0] c,
                                     input logic [7:0] e);
    int pos;
    pos = p.count;
    if (c == 0) return 1'b0;
    for (int i = 0; i < p.count; i++) begin
      if (p.expo[i] == e) begin
        p.coef[i] = c;
        return 1'b0;
      end
      if (e > p.expo[i]) begin
        pos = i;
        break;
      end
    end
    if (p.count >= SLOTS) return 1'b1;
    for (int i = p.count; i > pos; i--) begin
      p.coef[i] = p.coef[i-1];
      p.expo[i] = p.expo[i-1];
    end
    p.coef[pos] = c;
    p.expo[pos] = e;
    p.count++;
    return 1'b0;
  endfunction

  function automatic bit poly_sum_into_d();
    int i, j, k;
    bit lost;
    logic [31:0] c;
    logic [7:0] e;
    i = 0; j = 0; k = 0; lost = 1'b0;
    poly_clear(poly_d);
    while (i < poly_a.count || j < poly_b.count) begin
      if (i < poly_a.count && (j >= poly_b.count || poly_a.expo[i] > poly_b.expo[j])) begin
        c = poly_a.coef[i]; e = poly_a.expo[i]; i++;
      end else if (j < poly_b.count &&
                   (i >= poly_a.count || poly_b.expo[j] > poly_a.expo[i])) begin
        c = poly_b.coef[j]; e = poly_b.expo[j]; j++;
      end else begin
        c = poly_a.coef[i] + poly_b.coef[j]; e = poly_a.expo[i]; i++; j++;
      end
      if (c != 0) begin
        if (k < SLOTS) begin
          poly_d.coef[k] = c;
          poly_d.expo[k] = e;
          k++;
        end else begin
          lost = 1'b1;
        end
      end
    end
    poly_d.count = k;
    return lost;
  endfunction

  function automatic logic [31:0] poly_eval_d(logic [31:0] x);
    logic [31:0] acc, r, b;
    logic [7:0] e;
    acc = '0;
    for (int i = 0; i < poly_d.count; i++) begin
      r = 32'd1; b = x; e = poly_d.expo[i];
      while (e != 0) begin
        if (e[0]) r = r * b;
        b = b * b;
        e = e >> 1;
      end
      acc = acc + poly_d.coef[i] * r;
    end
    return acc;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    case (op_t'(it.op))
      OP_CLEAR: begin
        poly_clear(poly_a); poly_clear(poly_b); poly_clear(poly_d);
      end
      OP_INS_A: begin
        r.overflow = poly_insert(poly_a, it.coef_in, it.expo_in);
        r.term_count = 5'(poly_a.count);
      end
      OP_INS_B: begin
        r.overflow = poly_insert(poly_b, it.coef_in, it.expo_in);
        r.term_count = 5'(poly_b.count);
      end
      OP_MERGE: begin
        r.overflow = poly_sum_into_d();
        r.term_count = 5'(poly_d.count);
      end
      OP_EVAL: begin
        r.eval_value = poly_eval_d(it.x_value);
        r.term_count = 5'(poly_d.count);
      end
      OP_READ: begin
        if (it.term_index < poly_d.count) begin
          r.read_coef = poly_d.coef[it.term_index];
          r.read_expo = poly_d.expo[it.term_index];
          r.read_present = 1'b1;
        end
        r.term_count = 5'(poly_d.count);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_op(op_t op, logic [31:0] c, logic [7:0] e,
                                       logic [31:0] x, logic [3:0] idx);
    in_item_t it;
    it.op = op; it.coef_in = c; it.expo_in = e; it.x_value = x; it.term_index = idx;
    return it;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Sender: a new transfer may be offered at the falling edge after acceptance,
  // which the input monitor records by counting accepted operations.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || ops_sent == ops_offered) begin
        if (pending_ops.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 26)) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          ops_offered <= ops_offered + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= receiver_hold || (!quiet_mode && ($urandom_range(0, 99) < 26));
    end
  end

  // Long receiver hold-off while the sender keeps offering transfers.
  initial begin
    wait (ops_sent > 300);
    @(negedge clk);
    receiver_hold = 1'b1;
    repeat (400) @(negedge clk);
    receiver_hold = 1'b0;
  end

  // Input monitor: every accepted operation updates the prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(predict_result(in_data));
      ops_sent++;
    end
  end

  // Output monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.overflow) overflow_hits++;
        if (out_data.eval_value !== exp_r.eval_value) begin
          $error("eval_value exp %h got %h", exp_r.eval_value, out_data.eval_value);
          errors++;
        end
        if (out_data.read_coef !== exp_r.read_coef) begin
          $error("read_coef exp %h got %h", exp_r.read_coef, out_data.read_coef);
          errors++;
        end
        if (out_data.read_expo !== exp_r.read_expo) begin
          $error("read_expo exp %h got %h", exp_r.read_expo, out_data.read_expo);
          errors++;
        end
        if (out_data.read_present !== exp_r.read_present) begin
          $error("read_present exp %b got %b", exp_r.read_present, out_data.read_present);
          errors++;
        end
        if (out_data.overflow !== exp_r.overflow) begin
          $error("overflow exp %b got %b", exp_r.overflow, out_data.overflow);
          errors++;
        end
        if (out_data.term_count !== exp_r.term_count) begin
          $error("term_count exp %0d got %0d", exp_r.term_count, out_data.term_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sparse_polynomial_term_engine: mismatch");
      $finish;
    end
  end

  initial begin
    int seq_len;
    poly_clear(poly_a); poly_clear(poly_b); poly_clear(poly_d);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: evaluate an empty D, fill A past capacity, edge values.
    pending_ops.push_back(make_op(OP_EVAL, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_READ, '0, '0, '0, 4'hf));
    pending_ops.push_back(make_op(OP_INS_A, '0, 8'd5, '0, '0));       // zero coefficient
    for (int i = 0; i < 17; i++)
      pending_ops.push_back(make_op(OP_INS_A, 32'h8000_0000 + i, 8'(255 - 3 * i), '0, '0));
    pending_ops.push_back(make_op(OP_INS_A, 32'h7fff_ffff, 8'd255, '0, '0)); // overwrite
    pending_ops.push_back(make_op(OP_INS_B, 32'h8000_0000, 8'd255, '0, '0)); // sum is all ones
    pending_ops.push_back(make_op(OP_INS_B, 32'd7, 8'd0, '0, '0));
    pending_ops.push_back(make_op(OP_MERGE, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_EVAL, '0, '0, '0, '0));               // zero x
    pending_ops.push_back(make_op(OP_EVAL, '0, '0, 32'hffff_ffff, '0));
    pending_ops.push_back(make_op(OP_READ, '0, '0, '0, 4'd0));
    pending_ops.push_back(make_op(OP_UNUSED6, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 4'hf));
    pending_ops.push_back(make_op(OP_UNUSED7, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_CLEAR, '0, '0, '0, '0));

    // Random part: random ops and clears, or build A and B, merge, then evaluate and read back.
    while (pending_ops.size() < 1400) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_ops.push_back(make_op(op_t'($urandom_range(0, 7)), $urandom,
                                      8'($urandom), $urandom, 4'($urandom)));
        continue;
      end
      if ($urandom_range(0, 3) == 0)
        pending_ops.push_back(make_op(OP_CLEAR, '0, '0, '0, '0));
      seq_len = $urandom_range(1, 22);
      for (int i = 0; i < seq_len; i++)
        pending_ops.push_back(make_op($urandom_range(0, 1) ? OP_INS_A : OP_INS_B,
                                      rand_coef(),
                                      $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 7))
                                                                : 8'($urandom),
                                      $urandom, 4'($urandom)));
      pending_ops.push_back(make_op(OP_MERGE, $urandom, 8'($urandom), $urandom, 4'($urandom)));
      repeat ($urandom_range(1, 3))
        pending_ops.push_back(make_op(OP_EVAL, '0, '0,
                                      $urandom_range(0, 1) ? $urandom
                                                           : 32'($urandom_range(0, 4)) - 32'd2,
                                      '0));
      repeat ($urandom_range(1, 4))
        pending_ops.push_back(make_op(OP_READ, '0, '0, '0, 4'($urandom)));
    end

    wait (ops_sent > 700);
    quiet_mode = 1'b1;      // a stretch without any idling
    wait (ops_sent > 900);
    quiet_mode = 1'b0;

    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d operations checked, %0d results, %0d dropped-term cases",
             ops_sent, results_seen, overflow_hits);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("sparse_polynomial_term_engine: match");
    end else begin
      $display("sparse_polynomial_term_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sppt_pkg.sv
rtl/sppt_ctrl.sv
rtl/sppt_dp.sv
rtl/sparse_polynomial_term_engine.sv
rtl/sppt_checker.sv
tb/sparse_polynomial_term_engine_test.sv
